@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/stf_pkg.sv @@
// ----------------------------------------------------------------------------
// stf_pkg
// Types and constants of the sprite tile row fetch block.
// ----------------------------------------------------------------------------
`default_nettype none

package stf_pkg;

  localparam int MEMORY_BYTES     = 32768;
  localparam int TILE_COUNT       = 1024;
  localparam int TILES_PER_ROW    = 32;
  localparam int MAX_SPRITE_TILES = 8;

  localparam int ADDR_W   = $clog2(MEMORY_BYTES);
  localparam int TILE_W   = $clog2(TILE_COUNT);
  localparam int COL_W    = $clog2(TILES_PER_ROW);
  localparam int PIX_W    = 6;
  localparam int OFF_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int WT_W     = 4;
  localparam int ROW_W    = 6;

  // in_tdata field positions
  localparam int WA_LSB   = 0;
  localparam int WB_LSB   = 15;
  localparam int ST_LSB   = 23;
  localparam int DC_BIT   = 33;
  localparam int FV_BIT   = 34;
  localparam int FH_BIT   = 35;
  localparam int WT_LSB   = 36;
  localparam int HT_LSB   = 40;
  localparam int RO_LSB   = 44;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_FETCH = 1'b1;

  localparam logic REG_LINEAR_MAPPING = 1'b0;

  typedef struct packed {
    logic clear;
    logic write;
    logic load;
    logic setup;
    logic issue;
  } stf_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic width_zero;
    logic space;
    logic k_last;
    logic drained;
  } stf_sts_t;

  typedef struct packed {
    logic [BYTE_W-1:0] color;
    logic [PIX_W-1:0]  pos;
    logic              last;
  } stf_pix_t;

endpackage

`default_nettype wire

@@ hdl/sprite_tile_row_fetch_top.sv @@
// ----------------------------------------------------------------------------
// sprite_tile_row_fetch_top
// Sprite tile memory with one-row pixel fetch, stream in and out, APB config.
// ----------------------------------------------------------------------------
// After reset the 32768-byte tile memory is cleared one byte per cycle, and
// the input accepts no beat until the clear is done (configuration writes
// work throughout). A write beat stores one byte and leaves the input ready.
// A fetch beat of W tiles (W saturated to 8, W of zero gives nothing)
// returns 8*W pixel beats. The next beat is accepted only after a setup
// state, one read of the tile memory's single read port per pixel, the
// registered read data, the output queue, a check that the queue is drained
// and the return to idle. A two-entry output queue lets reads run while a
// finished pixel waits; output stalls pause the reads.
`default_nettype none

module sprite_tile_row_fetch_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: write_address, write_byte, start_tile, deep_color,
  // flip_vertical, flip_horizontal, width_tiles, height_tiles, row_offset
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [stf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: action
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_tdata: color_index, pixel_position
  output logic      [stf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                   out_tlast,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [2:0]                        cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic      [31:0]                       cfg_prdata,
  output logic                                   cfg_pready
);

  import stf_pkg::*;

  logic linear_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linear_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr[2] == REG_LINEAR_MAPPING)) begin
      linear_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LINEAR_MAPPING) ? {31'b0, linear_r} : 32'b0;

  stf_cmd_t          cmd;
  stf_sts_t          sts;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  stf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .linear_mapping (linear_r),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  stf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEMORY_BYTES)
  ) u_tile_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ hdl/stf_ram.sv @@
// ----------------------------------------------------------------------------
// stf_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/stf_ctrl.sv @@
// ----------------------------------------------------------------------------
// stf_ctrl
// Sequencer: memory clear, input acceptance, row setup, pixel reads, drain.
// ----------------------------------------------------------------------------
`default_nettype none

module stf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_action,
  output logic                   in_tready,
  input  wire stf_pkg::stf_sts_t sts,
  output stf_pkg::stf_cmd_t      cmd
);

  import stf_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_action == ACTION_WRITE) begin
            cmd.write = 1'b1;
          end else if (!sts.width_zero) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.issue = sts.space;
        if (sts.space && sts.k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.drained) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/stf_dp.sv @@
// ----------------------------------------------------------------------------
// stf_dp
// Datapath: clear counter, row address setup, pixel address generation,
// nibble select and two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stf_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire stf_pkg::stf_cmd_t                   cmd,
  output stf_pkg::stf_sts_t                        sts,
  input  wire logic                                linear_mapping,
  input  wire logic [stf_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [stf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                     out_tlast,
  output logic                                     ram_we,
  output logic      [stf_pkg::ADDR_W-1:0]          ram_waddr,
  output logic      [stf_pkg::BYTE_W-1:0]          ram_wdata,
  output logic                                     ram_re,
  output logic      [stf_pkg::ADDR_W-1:0]          ram_raddr,
  input  wire logic [stf_pkg::BYTE_W-1:0]          ram_rdata
);

  import stf_pkg::*;

  // input fields
  logic [WT_W-1:0]   in_wt;
  logic [WT_W-1:0]   in_wt_sat;
  assign in_wt     = in_tdata[WT_LSB +: WT_W];
  assign in_wt_sat = (in_wt > WT_W'(MAX_SPRITE_TILES)) ? WT_W'(MAX_SPRITE_TILES) : in_wt;

  // clear pass
  logic [ADDR_W-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + ADDR_W'(1);
    end
  end

  assign ram_we    = cmd.clear | cmd.write;
  assign ram_waddr = cmd.clear ? clr_r : in_tdata[WA_LSB +: ADDR_W];
  assign ram_wdata = cmd.clear ? '0 : in_tdata[WB_LSB +: BYTE_W];

  // fetch parameters
  logic [TILE_W-1:0] tile_r;
  logic              deep_r, vflip_r, hflip_r;
  logic [WT_W-1:0]   wt_r, ht_r;
  logic [ROW_W-1:0]  ro_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tile_r  <= in_tdata[ST_LSB +: TILE_W];
      deep_r  <= in_tdata[DC_BIT];
      vflip_r <= in_tdata[FV_BIT];
      hflip_r <= in_tdata[FH_BIT];
      wt_r    <= in_wt_sat;
      ht_r    <= in_tdata[HT_LSB +: WT_W];
      ro_r    <= in_tdata[RO_LSB +: ROW_W];
    end
  end

  // row setup
  logic [ROW_W-1:0]  srow;
  logic [2:0]        trow, ty;
  logic [6:0]        lin_prod;
  logic [7:0]        lin_base;
  logic [TILE_W-1:0] tile_even;
  logic [TILE_W-1:0] tbase_nxt;
  logic [OFF_W-1:0]  off_nxt;
  logic [PIX_W:0]    npix;

  always_comb begin
    srow      = vflip_r ? ({ht_r[2:0], 3'b000} - ROW_W'(1) - ro_r) : ro_r;
    trow      = srow[5:3];
    ty        = srow[2:0];
    lin_prod  = {4'b0000, trow} * {3'b000, wt_r};
    lin_base  = deep_r ? {lin_prod, 1'b0} : {1'b0, lin_prod};
    tile_even = deep_r ? {tile_r[TILE_W-1:1], 1'b0} : tile_r;
    if (linear_mapping) begin
      tbase_nxt = tile_r + TILE_W'(lin_base);
    end else begin
      tbase_nxt = tile_even + TILE_W'({trow, {COL_W{1'b0}}});
    end
    off_nxt = deep_r ? {ty, 3'b000} : {1'b0, ty, 2'b00};
    npix    = {wt_r, 3'b000};
  end

  logic [TILE_W-1:0] tbase_r;
  logic [OFF_W-1:0]  off_r;
  logic [PIX_W-1:0]  last_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      tbase_r <= tbase_nxt;
      off_r   <= off_nxt;
      last_r  <= PIX_W'(npix - (PIX_W+1)'(1));
    end
  end

  // pixel address generation
  logic [PIX_W-1:0]  k_r;
  logic [PIX_W-1:0]  src;
  logic [3:0]        tinc;
  logic [COL_W-1:0]  col;
  logic [TILE_W-1:0] tnum;
  logic [2:0]        byte_sel;
  logic [OFF_W-1:0]  in_off;

  always_comb begin
    src      = hflip_r ? (last_r - k_r) : k_r;
    tinc     = deep_r ? {src[5:3], 1'b0} : {1'b0, src[5:3]};
    col      = tbase_r[COL_W-1:0] + COL_W'(tinc);
    tnum     = linear_mapping ? (tbase_r + TILE_W'(tinc))
                              : {tbase_r[TILE_W-1:COL_W], col};
    byte_sel = deep_r ? src[2:0] : {1'b0, src[2:1]};
    in_off   = off_r + OFF_W'(byte_sel);
  end

  assign ram_re    = cmd.issue;
  assign ram_raddr = {tnum, 5'b00000} + ADDR_W'(in_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.setup) begin
      k_r <= '0;
    end else if (cmd.issue) begin
      k_r <= k_r + PIX_W'(1);
    end
  end

  // read sideband
  logic             rd_valid_r;
  logic [PIX_W-1:0] rd_pos_r;
  logic             rd_last_r;
  logic             rd_nib_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_pos_r  <= k_r;
      rd_last_r <= (k_r == last_r);
      rd_nib_r  <= src[0];
    end
  end

  // output queue
  stf_pix_t   q0_r, q1_r, q0_nxt, q1_nxt, pix_in;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  logic [2:0] occ;

  assign push         = rd_valid_r;
  assign pop          = (cnt_r != 2'd0) && out_tready;
  assign pix_in.color = deep_r ? ram_rdata
                      : (rd_nib_r ? {4'b0000, ram_rdata[7:4]} : {4'b0000, ram_rdata[3:0]});
  assign pix_in.pos   = rd_pos_r;
  assign pix_in.last  = rd_last_r;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q0_nxt = pix_in;
        end else begin
          q1_nxt = pix_in;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt  = q1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          q0_nxt = pix_in;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = pix_in;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign occ        = {1'b0, cnt_r} + {2'b00, rd_valid_r};
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {{(OUT_TDATA_W-BYTE_W-PIX_W){1'b0}}, q0_r.pos, q0_r.color};
  assign out_tlast  = q0_r.last;

  // status
  assign sts.clr_done   = (clr_r == {ADDR_W{1'b1}});
  assign sts.width_zero = (in_wt == '0);
  assign sts.space      = (occ < 3'd2) || ((occ == 3'd2) && pop);
  assign sts.k_last     = (k_r == last_r);
  assign sts.drained    = (cnt_r == 2'd0) && !rd_valid_r;

  `STF_ASSERT_NOW(a_occ_bound, 1'b1, occ <= 3'd2, "output queue overrun")
  `STF_ASSERT_NOW(a_last_pos, push && rd_last_r, rd_pos_r == last_r, "last beat misplaced")
  `STF_ASSERT_NEXT(a_k_hold, !cmd.issue && !cmd.setup, $stable(k_r), "pixel counter moved")

endmodule

`default_nettype wire

@@ tb/tb_sprite_tile_row_fetch_top.sv @@
// ----------------------------------------------------------------------------
// tb_sprite_tile_row_fetch_top
// Self-checking bench for the sprite tile row fetch block. Byte writes and row
// fetches go in on the input stream under random gaps while the pixel stream
// stalls at random. A shadow copy of the tile memory and the layout register
// predicts every pixel beat, which is compared field by field in order. Runs
// cover both tile layouts, a fixed set of corner cases and random sprites
// whose rows are mostly seeded with written bytes before they are fetched.
// ----------------------------------------------------------------------------
module tb_sprite_tile_row_fetch_top;
  import stf_pkg::*;

  localparam int unsigned TILE_BYTES  = 32;
  localparam int unsigned GRID_ROW    = TILES_PER_ROW * TILE_BYTES;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam logic [2:0]  LINEAR_ADDR = 3'(4 * int'(REG_LINEAR_MAPPING));

  // expected pixel stream of the rows fetched so far
  class row_pixel_board;
    logic [BYTE_W-1:0] tile_mem [MEMORY_BYTES];
    bit                linear;
    stf_pix_t          pending_pix[$];
    int unsigned       failures;
    int unsigned       pixels_seen;
    int unsigned       rows_fetched;
    int unsigned       bytes_written;

    function new();
      foreach (tile_mem[i]) tile_mem[i] = '0;
      linear = 1'b0;
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      failures++;
      if (failures <= 10) begin
        $display("mismatch on %s at pixel beat %0d: expected %0d, got %0d",
                 what, pixels_seen, want, got);
      end
    endfunction

    // byte addresses read by one fetch, in unflipped row order
    function void row_addresses(input logic [IN_TDATA_W-1:0] d,
                                output int unsigned addrs[$]);
      int unsigned tile, wt, ht, ro, srow, trow, ty, stride, addr, maxrow;
      bit deep, vf;
      addrs.delete();
      tile   = d[ST_LSB +: TILE_W];
      deep   = d[DC_BIT];
      vf     = d[FV_BIT];
      wt     = d[WT_LSB +: WT_W];
      ht     = d[HT_LSB +: WT_W];
      ro     = d[RO_LSB +: ROW_W];
      if (wt > MAX_SPRITE_TILES) wt = MAX_SPRITE_TILES;
      srow   = vf ? ((ht * 8 - 1 - ro) & 32'h3F) : ro;
      trow   = srow >> 3;
      ty     = srow & 7;
      stride = deep ? 8 : 4;
      maxrow = 0;
      if (linear) begin
        addr = (tile + trow * wt * (deep ? 2 : 1)) * TILE_BYTES + ty * stride;
      end else begin
        if (deep) tile = tile & ~32'd1;
        tile   = (tile + trow * TILES_PER_ROW) % TILE_COUNT;
        maxrow = (tile / TILES_PER_ROW + 1) * GRID_ROW - 1;
        addr   = tile * TILE_BYTES + ty * stride;
      end
      for (int unsigned t = 0; t < wt; t++) begin
        if (linear) addr = addr % MEMORY_BYTES;
        else if (addr > maxrow) addr -= GRID_ROW;
        for (int unsigned j = 0; j < stride; j++) begin
          addrs.push_back((addr + j) % MEMORY_BYTES);
        end
        addr += deep ? 2 * TILE_BYTES : TILE_BYTES;
      end
    endfunction

    function void note_beat(input logic act, input logic [IN_TDATA_W-1:0] d);
      int unsigned       addrs[$];
      logic [BYTE_W-1:0] row_pix[$];
      logic [BYTE_W-1:0] b;
      stf_pix_t          pix;
      int unsigned       n;
      if (act == ACTION_WRITE) begin
        tile_mem[d[WA_LSB +: ADDR_W]] = d[WB_LSB +: BYTE_W];
        bytes_written++;
        return;
      end
      row_addresses(d, addrs);
      foreach (addrs[i]) begin
        b = tile_mem[addrs[i]];
        if (d[DC_BIT]) begin
          row_pix.push_back(b);
        end else begin
          row_pix.push_back({4'h0, b[3:0]});
          row_pix.push_back({4'h0, b[7:4]});
        end
      end
      n = row_pix.size();
      if (n == 0) return;
      rows_fetched++;
      for (int unsigned k = 0; k < n; k++) begin
        pix.color = row_pix[d[FH_BIT] ? n - 1 - k : k];
        pix.pos   = PIX_W'(k);
        pix.last  = (k == n - 1);
        pending_pix.push_back(pix);
      end
    endfunction

    function void check_pixel(input logic [OUT_TDATA_W-1:0] td, input logic tl);
      stf_pix_t want;
      pixels_seen++;
      if (pending_pix.size() == 0) begin
        flag("unexpected pixel, color_index", 0, td[BYTE_W-1:0]);
        return;
      end
      want = pending_pix.pop_front();
      if (td[BYTE_W-1:0] !== want.color) flag("color_index", want.color, td[BYTE_W-1:0]);
      if (td[BYTE_W +: PIX_W] !== want.pos) flag("pixel_position", want.pos, td[BYTE_W +: PIX_W]);
      if (tl !== want.last) flag("last_pixel", want.last, tl);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [2:0]            cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  row_pixel_board board;
  int unsigned    cycles;
  int unsigned    rdy_hold;
  int unsigned    beats_sent;

  sprite_tile_row_fetch_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixel beats outstanding",
               cycles, board.pending_pix.size());
      $display("sprite_tile_row_fetch_top regression: fail");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result-side backpressure: short stalls mostly, a few long, and long open runs
  always @(posedge clk) begin
    if (rdy_hold != 0) begin
      rdy_hold--;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      rdy_hold = pick_gap();
    end else begin
      out_tready <= 1'b1;
      rdy_hold = ($urandom_range(0, 9) < 2) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_pixel(out_tdata, out_tlast);
  end

  function automatic logic [IN_TDATA_W-1:0] rand_tdata();
    logic [63:0] r;
    r = {$urandom, $urandom};
    r[63:RO_LSB+ROW_W] = '0;
    return r[IN_TDATA_W-1:0];
  endfunction

  function automatic logic [IN_TDATA_W-1:0] mk_beat(
      int unsigned wa, int unsigned wb, int unsigned st, bit dc, bit fv, bit fh,
      int unsigned wt, int unsigned ht, int unsigned ro);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[WA_LSB +: ADDR_W] = ADDR_W'(wa);
    d[WB_LSB +: BYTE_W] = BYTE_W'(wb);
    d[ST_LSB +: TILE_W] = TILE_W'(st);
    d[DC_BIT]           = dc;
    d[FV_BIT]           = fv;
    d[FH_BIT]           = fh;
    d[WT_LSB +: WT_W]   = WT_W'(wt);
    d[HT_LSB +: WT_W]   = WT_W'(ht);
    d[RO_LSB +: ROW_W]  = ROW_W'(ro);
    return d;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pick_fetch(bit well_formed);
    logic [IN_TDATA_W-1:0] d;
    int unsigned ht;
    d = rand_tdata();
    if (well_formed) begin
      ht = $urandom_range(1, 8);
      d[WT_LSB +: WT_W]  = WT_W'($urandom_range(1, 8));
      d[HT_LSB +: WT_W]  = WT_W'(ht);
      d[RO_LSB +: ROW_W] = ROW_W'($urandom_range(0, ht * 8 - 1));
    end
    return d;
  endfunction

  task automatic send_beat(input logic act, input logic [IN_TDATA_W-1:0] d);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    board.note_beat(act, d);
    beats_sent++;
  endtask

  // hold the input until all pixels are back, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_pix.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == LINEAR_ADDR) board.linear = val[0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [2:0] addr, output logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    val = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mapping(input bit lin);
    logic [31:0] rd;
    cfg_write(LINEAR_ADDR, {31'd0, lin});
    cfg_read(LINEAR_ADDR, rd);
    if (rd[0] !== lin) board.flag("linear_mapping read-back", lin, rd[0]);
  endtask

  task automatic run_directed_grid();
    send_beat(ACTION_WRITE, mk_beat(0, 8'hFF, 0, 0, 0, 0, 0, 0, 0));
    send_beat(ACTION_WRITE, mk_beat(1, 8'h5A, 0, 0, 0, 0, 0, 0, 0));
    send_beat(ACTION_WRITE, mk_beat(15'h7FFF, 8'hC3, 0, 0, 0, 0, 0, 0, 0));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 0, 0, 0, 0, 1, 1, 0));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 0, 1, 0, 0, 1, 1, 0));
    send_beat(ACTION_WRITE, mk_beat(15'h7FE0, 8'h81, 0, 0, 0, 0, 0, 0, 0));
    // grid wrap at the top tile numbers
    send_beat(ACTION_FETCH, mk_beat(0, 0, 1023, 0, 0, 0, 8, 8, 63));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 1023, 1, 1, 0, 8, 8, 0));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 5, 0, 0, 0, 0, 2, 3));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 2, 0, 0, 1, 15, 2, 9));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 0, 0, 1, 0, 1, 0, 5));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 0, 1, 1, 1, 2, 15, 63));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 3, 0, 0, 0, 3, 1, 63));
    send_beat(ACTION_WRITE, {IN_TDATA_W{1'b1}} >> (IN_TDATA_W - RO_LSB - ROW_W));
    send_beat(ACTION_FETCH, {IN_TDATA_W{1'b1}} >> (IN_TDATA_W - RO_LSB - ROW_W));
    send_beat(ACTION_WRITE, '0);
    send_beat(ACTION_FETCH, '0);
    send_beat(ACTION_FETCH, mk_beat(0, 0, 0, 0, 0, 0, 1, 1, 0));
  endtask

  task automatic run_directed_linear();
    send_beat(ACTION_FETCH, mk_beat(0, 0, 1023, 1, 0, 0, 8, 8, 63));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 1020, 0, 1, 1, 8, 8, 0));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_beat(ACTION_FETCH, mk_beat(0, 0, 1, 1, 0, 0, 15, 3, 17));
  endtask

  // mostly sprites whose fetched row is seeded with fresh bytes first
  task automatic run_random(input int unsigned items);
    logic [IN_TDATA_W-1:0] d, w;
    int unsigned addrs[$];
    int unsigned sent, r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        d = pick_fetch(r < 60);
        board.row_addresses(d, addrs);
        if (addrs.size() != 0) begin
          repeat ($urandom_range(1, 5)) begin
            w = rand_tdata();
            w[WA_LSB +: ADDR_W] = ADDR_W'(addrs[$urandom_range(0, addrs.size() - 1)]);
            send_beat(ACTION_WRITE, w);
            sent++;
          end
        end
        send_beat(ACTION_FETCH, d);
        sent++;
      end else if (r < 85) begin
        send_beat(ACTION_WRITE, rand_tdata());
        sent++;
      end else if (r < 97) begin
        send_beat(ACTION_FETCH, rand_tdata());
        sent++;
      end else begin
        settle();
      end
    end
  endtask

  initial begin
    logic [31:0] rd;
    board       = new();
    cycles      = 0;
    rdy_hold    = 0;
    beats_sent  = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= ACTION_WRITE;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_read(LINEAR_ADDR, rd);
    if (rd[0] !== 1'b0) board.flag("linear_mapping after reset", 0, rd[0]);
    set_mapping(1'b1);
    set_mapping(1'b0);
    run_directed_grid();
    settle();
    set_mapping(1'b1);
    run_directed_linear();
    run_random(35);
    settle();
    set_mapping(1'b0);
    run_random(35);
    settle();
    set_mapping(1'b1);
    run_random(30);
    settle();

    $display("%0d input beats: %0d tile bytes written, %0d rows fetched in both layouts",
             beats_sent, board.bytes_written, board.rows_fetched);
    $display("%0d pixel beats checked, %0d mismatches", board.pixels_seen, board.failures);
    if (board.failures == 0) begin
      $display("sprite_tile_row_fetch_top regression: pass");
    end else begin
      $display("sprite_tile_row_fetch_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/stf_pkg.sv
hdl/stf_ram.sv
hdl/stf_ctrl.sv
hdl/stf_dp.sv
hdl/sprite_tile_row_fetch_top.sv
tb/tb_sprite_tile_row_fetch_top.sv
